FILE: rtl/core/xild_pkg.sv
// Shared types, constants and opcode tables for the x86 length decoder.
package xild_pkg;

   localparam int MAX_LENGTH = 15;
   localparam int LEN_W      = 4;
   localparam int CNT_W      = 3;

   localparam logic [7:0] PFX_LOCK  = 8'hF0;
   localparam logic [7:0] PFX_REPNE = 8'hF2;
   localparam logic [7:0] PFX_REP   = 8'hF3;
   localparam logic [7:0] PFX_OPSZ  = 8'h66;
   localparam logic [7:0] PFX_ADSZ  = 8'h67;
   localparam logic [7:0] PFX_FS    = 8'h64;
   localparam logic [7:0] PFX_GS    = 8'h65;
   localparam logic [7:0] OP_ESC    = 8'h0F;

   localparam logic [1:0] MOD_REG  = 2'b11;
   localparam logic [1:0] MOD_D8   = 2'b01;
   localparam logic [1:0] MOD_D32  = 2'b10;
   localparam logic [2:0] RM_SIB   = 3'b100;
   localparam logic [2:0] RM_RIP   = 3'b101;

   typedef struct packed {
      logic [LEN_W-1:0] instr_length;
      logic             rel_present;
      logic [LEN_W-1:0] rel_offset;
      logic             too_long;
   } rsp_type;

   // opcode class: ModRM follows, immediate size, 4-byte relative field,
   // 2-byte branch offset (0F 8x after 66)
   typedef struct packed {
      logic             modrm;
      logic [CNT_W-1:0] imm;
      logic             rel;
      logic             short_disp;
   } opc_type;

   function automatic logic is_prefix(input logic [7:0] b);
      return b == PFX_LOCK || b == PFX_REPNE || b == PFX_REP || b == PFX_OPSZ ||
             b == PFX_ADSZ || b == PFX_FS || b == PFX_GS;
   endfunction

   function automatic opc_type class_one(input logic [7:0] op, input logic size_pfx);
      opc_type          c;
      logic [CNT_W-1:0] wide;
      c    = '0;
      wide = size_pfx ? 3'd2 : 3'd4;
      if (op < 8'h40 && op[2:0] <= 3'd5) begin
         if (op[2:0] < 3'd4) c.modrm = 1'b1;
         else if (op[2:0] == 3'd4) c.imm = 3'd1;
         else c.imm = wide;
      end else if ((op >= 8'h70 && op <= 8'h7F) || (op >= 8'hB0 && op <= 8'hB7) ||
                   op == 8'h6A || op == 8'hCD || op == 8'hEB) begin
         c.imm = 3'd1;
      end else if ((op >= 8'hB8 && op <= 8'hBF) || op == 8'h68 ||
                   op == 8'hA8 || op == 8'hA9) begin
         c.imm = wide;
      end else if (op == 8'hC2 || op == 8'hC8 || op == 8'hCA) begin
         c.imm = 3'd2;
      end else if (op == 8'h6B || op == 8'h80 || op == 8'h82 || op == 8'h83 ||
                   op == 8'hC0 || op == 8'hC1 || op == 8'hC6) begin
         c.modrm = 1'b1;
         c.imm   = 3'd1;
      end else if (op == 8'h81 || op == 8'hC7) begin
         c.modrm = 1'b1;
         c.imm   = wide;
      end else if ((op >= 8'h84 && op <= 8'h8F) || op == 8'h69 || op == 8'hD9 ||
                   op == 8'hDB || op == 8'hFE || op == 8'hFF) begin
         c.modrm = 1'b1;
      end else if ((op >= 8'hA0 && op <= 8'hA3) || op == 8'hE8 || op == 8'hE9) begin
         c.rel = 1'b1;
      end
      return c;
   endfunction

   function automatic opc_type class_two(input logic [7:0] op, input logic size_pfx);
      opc_type c;
      c = '0;
      if (op >= 8'h80 && op <= 8'h8F) begin
         if (size_pfx) c.short_disp = 1'b1;
         else c.rel = 1'b1;
      end else if (op == 8'h1F || (op >= 8'h90 && op <= 8'h9F) ||
                   op == 8'hB6 || op == 8'hB7) begin
         c.modrm = 1'b1;
      end else if (op == 8'hBA) begin
         c.modrm = 1'b1;
         c.imm   = 3'd1;
      end
      return c;
   endfunction

endpackage

FILE: rtl/core/xild_in_stage.sv
// Input register for code bytes.
module xild_in_stage
   import xild_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_code_byte,
   output logic       byte_valid,
   output logic [7:0] byte_data,
   input  logic       byte_take
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;

   assign req_ready  = !valid_ff || byte_take;
   assign valid_in   = (req_valid && req_ready) || (valid_ff && !byte_take);
   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         byte_ff <= req_code_byte;
      end
   end

endmodule

FILE: rtl/core/xild_step.sv
// Per-byte decode state and next-state logic.
module xild_step
   import xild_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic [7:0] byte_data,
   input  logic       out_free,
   output logic       byte_take,
   output logic       rsp_load,
   output rsp_type    rsp_data
);

   typedef enum logic [2:0] {
      PH_LEAD, PH_OP2, PH_MODRM, PH_SIB, PH_DISP, PH_IMM
   } phase_type;

   typedef struct packed {
      phase_type        phase;
      logic [CNT_W-1:0] left;
      logic             done;
   } tail_type;

   function automatic tail_type enter_tail(input logic [CNT_W-1:0] disp,
                                           input logic [CNT_W-1:0] imm,
                                           input phase_type cur);
      tail_type t;
      t.phase = cur;
      t.left  = '0;
      t.done  = 1'b0;
      if (disp != '0) begin
         t.phase = PH_DISP;
         t.left  = disp;
      end else if (imm != '0) begin
         t.phase = PH_IMM;
         t.left  = imm;
      end else begin
         t.done = 1'b1;
      end
      return t;
   endfunction

   phase_type        phase_ff, phase_in;
   logic             size_ff, size_in;
   logic             modrm_ff, modrm_in;
   logic [CNT_W-1:0] imm_ff, imm_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0] disp_ff, disp_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic             rel_ff, rel_in;
   logic [LEN_W-1:0] relpos_ff, relpos_in;

   phase_type        ph_v;
   logic             size_v, modrm_v, rel_v, done;
   logic [CNT_W-1:0] imm_v, left_v, disp_v, left_dec;
   logic [LEN_W-1:0] len, relpos_v;
   logic             emit;
   opc_type          cls;
   tail_type         tl;

   always_comb begin
      ph_v     = phase_ff;
      size_v   = size_ff;
      modrm_v  = modrm_ff;
      imm_v    = imm_ff;
      left_v   = left_ff;
      disp_v   = disp_ff;
      rel_v    = rel_ff;
      relpos_v = relpos_ff;
      done     = 1'b0;
      len      = length_ff + 1'b1;
      left_dec = (left_ff != '0) ? left_ff - 1'b1 : left_ff;
      cls      = '0;
      tl       = '0;
      case (phase_ff)
         PH_OP2, PH_LEAD: begin
            if (phase_ff == PH_OP2) begin
               cls = class_two(byte_data, size_ff);
            end else begin
               cls = class_one(byte_data, size_ff);
            end
            if (phase_ff == PH_LEAD && is_prefix(byte_data)) begin
               if (byte_data == PFX_OPSZ) size_v = 1'b1;
            end else if (phase_ff == PH_LEAD && byte_data == OP_ESC) begin
               ph_v = PH_OP2;
            end else begin
               if (cls.modrm) modrm_v = 1'b1;
               if (cls.imm != '0) imm_v = cls.imm;
               if (cls.short_disp) disp_v = 3'd2;
               if (cls.rel) begin
                  rel_v    = 1'b1;
                  relpos_v = len;
                  disp_v   = 3'd4;
               end
               if (modrm_v) begin
                  ph_v = PH_MODRM;
               end else begin
                  tl     = enter_tail(disp_v, imm_v, phase_ff);
                  ph_v   = tl.phase;
                  left_v = (tl.done) ? left_v : tl.left;
                  done   = tl.done;
               end
            end
         end
         PH_MODRM: begin
            modrm_v = 1'b0;
            if (byte_data[7:6] != MOD_REG) begin
               if (byte_data[7:6] == MOD_D8) disp_v = 3'd1;
               else if (byte_data[7:6] == MOD_D32) disp_v = 3'd4;
               else if (byte_data[2:0] == RM_RIP) begin
                  rel_v    = 1'b1;
                  relpos_v = len;
                  disp_v   = 3'd4;
               end
            end
            if (byte_data[7:6] != MOD_REG && byte_data[2:0] == RM_SIB) begin
               ph_v = PH_SIB;
            end else begin
               tl     = enter_tail(disp_v, imm_v, phase_ff);
               ph_v   = tl.phase;
               left_v = (tl.done) ? left_v : tl.left;
               done   = tl.done;
            end
         end
         PH_SIB: begin
            tl     = enter_tail(disp_v, imm_v, phase_ff);
            ph_v   = tl.phase;
            left_v = (tl.done) ? left_v : tl.left;
            done   = tl.done;
         end
         PH_DISP: begin
            left_v = left_dec;
            if (left_dec == '0) begin
               disp_v = '0;
               tl     = enter_tail('0, imm_v, phase_ff);
               ph_v   = tl.phase;
               left_v = (tl.done) ? left_v : tl.left;
               done   = tl.done;
            end
         end
         PH_IMM: begin
            left_v = left_dec;
            done   = (left_dec == '0);
         end
         default: begin
            ph_v = PH_LEAD;
         end
      endcase
      emit = done || (len >= LEN_W'(MAX_LENGTH));
   end

   // a byte that ends an instruction needs room in the result register
   assign byte_take = byte_valid && (!emit || out_free);
   assign rsp_load  = byte_take && emit;

   assign rsp_data.instr_length = len;
   assign rsp_data.rel_present  = rel_v;
   assign rsp_data.rel_offset   = rel_v ? relpos_v : '0;
   assign rsp_data.too_long     = !done;

   always_comb begin
      if (emit) begin
         phase_in  = PH_LEAD;
         size_in   = 1'b0;
         modrm_in  = 1'b0;
         imm_in    = '0;
         left_in   = '0;
         disp_in   = '0;
         length_in = '0;
         rel_in    = 1'b0;
         relpos_in = '0;
      end else begin
         phase_in  = ph_v;
         size_in   = size_v;
         modrm_in  = modrm_v;
         imm_in    = imm_v;
         left_in   = left_v;
         disp_in   = disp_v;
         length_in = len;
         rel_in    = rel_v;
         relpos_in = relpos_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LEAD;
         size_ff   <= 1'b0;
         modrm_ff  <= 1'b0;
         imm_ff    <= '0;
         left_ff   <= '0;
         disp_ff   <= '0;
         length_ff <= '0;
         rel_ff    <= 1'b0;
         relpos_ff <= '0;
      end else if (byte_take) begin
         phase_ff  <= phase_in;
         size_ff   <= size_in;
         modrm_ff  <= modrm_in;
         imm_ff    <= imm_in;
         left_ff   <= left_in;
         disp_ff   <= disp_in;
         length_ff <= length_in;
         rel_ff    <= rel_in;
         relpos_ff <= relpos_in;
      end
   end

endmodule

FILE: rtl/core/xild_out_stage.sv
// Result register for completed instructions.
module xild_out_stage
   import xild_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             rsp_load,
   input  rsp_type          rsp_data,
   output logic             out_free,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [LEN_W-1:0] rsp_instr_length,
   output logic             rsp_rel_present,
   output logic [LEN_W-1:0] rsp_rel_offset,
   output logic             rsp_too_long
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign out_free = !valid_ff || rsp_ready;
   assign valid_in = rsp_load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (rsp_load) begin
         data_ff <= rsp_data;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_instr_length = data_ff.instr_length;
   assign rsp_rel_present  = data_ff.rel_present;
   assign rsp_rel_offset   = data_ff.rel_offset;
   assign rsp_too_long     = data_ff.too_long;

endmodule

FILE: rtl/core/x86_instruction_length_decoder_unit.sv
// The last byte of an instruction is registered in the input register, then its result
// in the result register. Throughput: one code byte per cycle while nothing stalls; the
// decode state steps once per byte in a combinational next-state loop between them.
// A byte ending an instruction waits only while the result register is still held.
// Reset (synchronous): decoder returns to the prefix/opcode phase, both registers empty.
module x86_instruction_length_decoder_unit
   import xild_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_code_byte,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [LEN_W-1:0] rsp_instr_length,
   output logic             rsp_rel_present,
   output logic [LEN_W-1:0] rsp_rel_offset,
   output logic             rsp_too_long
);

   logic       byte_valid, byte_take, out_free, rsp_load;
   logic [7:0] byte_data;
   rsp_type    rsp_data;

   xild_in_stage u_in (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_code_byte (req_code_byte),
      .byte_valid    (byte_valid),
      .byte_data     (byte_data),
      .byte_take     (byte_take)
   );

   xild_step u_step (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .byte_data  (byte_data),
      .out_free   (out_free),
      .byte_take  (byte_take),
      .rsp_load   (rsp_load),
      .rsp_data   (rsp_data)
   );

   xild_out_stage u_out (
      .clock            (clock),
      .reset            (reset),
      .rsp_load         (rsp_load),
      .rsp_data         (rsp_data),
      .out_free         (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_instr_length (rsp_instr_length),
      .rsp_rel_present  (rsp_rel_present),
      .rsp_rel_offset   (rsp_rel_offset),
      .rsp_too_long     (rsp_too_long)
   );

endmodule

FILE: rtl/core/xild_checker.sv
// Port-level checks for the length decoder, bound to the top level.
module xild_checker
   import xild_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [LEN_W-1:0] rsp_instr_length,
   input logic             rsp_rel_present,
   input logic [LEN_W-1:0] rsp_rel_offset,
   input logic             rsp_too_long
);

   // a held item stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_instr_length) &&
      $stable(rsp_rel_present) && $stable(rsp_rel_offset) && $stable(rsp_too_long))
      else $error("result changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_cut_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_long |-> rsp_instr_length == LEN_W'(MAX_LENGTH))
      else $error("too-long item with wrong length");

   a_rel_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_instr_length != '0 &&
      (rsp_rel_present ? (rsp_rel_offset != '0 && rsp_rel_offset <= rsp_instr_length)
                       : rsp_rel_offset == '0))
      else $error("relative offset inconsistent with length");

   // no result can come out without some byte having been taken before
   a_rsp_needs_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) |-> $past(req_valid, 2) || $past(req_valid, 3) ||
      $past(rsp_ready) || !$past(req_ready))
      else $error("result without input");

endmodule

bind x86_instruction_length_decoder_unit xild_checker u_xild_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_instr_length (rsp_instr_length),
   .rsp_rel_present  (rsp_rel_present),
   .rsp_rel_offset   (rsp_rel_offset),
   .rsp_too_long     (rsp_too_long)
);

FILE: sim/x86_instruction_length_decoder_unit_tb.sv
// Self-checking testbench for the byte-serial x86 instruction length decoder.
module x86_instruction_length_decoder_unit_tb;
   import xild_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES = 250;
   localparam int MAX_REPORTS = 10;

   // hand-picked instructions covering the table quirks and edge cases
   localparam DIRECTED_BYTES = {
      8'h90,                                        // opcode not in table
      8'h00, 8'hC0,                                 // ModRM, register form
      8'h69, 8'h05, 8'h11, 8'h22, 8'h33, 8'h44,     // 69 without immediate, RIP-relative
      8'h66, 8'hA8, 8'h12, 8'h34,                   // A8 wide immediate, shortened
      8'hA8, 8'h01, 8'h02, 8'h03, 8'h04,            // A8 wide immediate
      8'hC8, 8'h01, 8'h02,                          // C8 two-byte immediate
      8'hA1, 8'h11, 8'h22, 8'h33, 8'h44,            // moffs marked relative
      8'h66, 8'hE8, 8'h00, 8'h00, 8'h00, 8'h00,     // call keeps 4 bytes after 66
      8'h66, 8'h0F, 8'h85, 8'h01, 8'h02,            // short branch offset
      8'h0F, 8'h85, 8'h01, 8'h02, 8'h03, 8'h04,     // near branch, relative
      8'h8B, 8'h04, 8'h25,                          // SIB base 101, no displacement
      8'h0F, 8'h66,                                 // prefix value after escape
      8'hF0, 8'hF2, 8'hF3, 8'h67, 8'h64, 8'h65, 8'h90,
      8'h81, 8'h84, 8'h24, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88,
      8'h66, 8'hC7, 8'h40, 8'h01, 8'hAA, 8'hBB,     // disp8 plus short immediate
      8'h0F, 8'hBA, 8'hE0, 8'h05,
      8'hFF, 8'hFF,
      8'hC3
   };

   localparam LISTED_OPS = {
      8'h70, 8'h7F, 8'hB0, 8'hB7, 8'h6A, 8'hCD, 8'hEB, 8'hB8, 8'hBF, 8'h68,
      8'hA8, 8'hA9, 8'hC2, 8'hC8, 8'hCA, 8'h6B, 8'h80, 8'h82, 8'h83, 8'hC0,
      8'hC1, 8'hC6, 8'h81, 8'hC7, 8'h84, 8'h8B, 8'h8F, 8'h69, 8'hD9, 8'hDB,
      8'hFE, 8'hFF, 8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'hE8, 8'hE9
   };

   localparam ESCAPED_OPS = {
      8'h80, 8'h85, 8'h8F, 8'h1F, 8'h90, 8'h9F, 8'hB6, 8'hB7, 8'hBA
   };

   typedef enum logic [2:0] {
      ST_LEAD, ST_OP2, ST_MODRM, ST_SIB, ST_DISP, ST_IMM
   } dec_state_type;

   typedef struct packed {
      dec_state_type st;
      logic          opsz;
      logic          need_modrm;
      logic          rel_f;
      logic [2:0]    imm_n;
      logic [2:0]    left_n;
      logic [2:0]    disp_n;
      logic [3:0]    len_acc;
      logic [3:0]    rel_pos;
   } dec_ctx_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [7:0]       req_code_byte = 8'h00;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [LEN_W-1:0] rsp_instr_length;
   logic             rsp_rel_present;
   logic [LEN_W-1:0] rsp_rel_offset;
   logic             rsp_too_long;

   logic [7:0]  pending_bytes [$];
   rsp_type     expected_lengths [$];
   dec_ctx_type dut_ctx;
   dec_ctx_type gen_ctx;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_tag = 0;
   int hold_taken = 0;
   int hold_left = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_too_long = 0;
   int n_rel = 0;
   int mismatches = 0;

   x86_instruction_length_decoder_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_code_byte    (req_code_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_instr_length (rsp_instr_length),
      .rsp_rel_present  (rsp_rel_present),
      .rsp_rel_offset   (rsp_rel_offset),
      .rsp_too_long     (rsp_too_long)
   );

   always #5 clock = ~clock;

   function automatic dec_ctx_type ctx_clear();
      dec_ctx_type c;
      c = '0;
      c.st = ST_LEAD;
      return c;
   endfunction

   function automatic void mark_rel4(inout dec_ctx_type c, input logic [3:0] pos);
      c.rel_f   = 1'b1;
      c.rel_pos = pos;
      c.disp_n  = 3'd4;
   endfunction

   function automatic void class_primary(inout dec_ctx_type c, input logic [7:0] op,
                                         input logic [3:0] pos);
      logic [2:0] wide;
      wide = c.opsz ? 3'd2 : 3'd4;
      if (op < 8'h40 && op[2:0] <= 3'd5) begin
         if (op[2:0] < 3'd4) c.need_modrm = 1'b1;
         else if (op[2:0] == 3'd4) c.imm_n = 3'd1;
         else c.imm_n = wide;
      end else begin
         casez (op)
            8'h7?, 8'b1011_0???, 8'h6A, 8'hCD, 8'hEB: c.imm_n = 3'd1;
            8'b1011_1???, 8'h68, 8'hA8, 8'hA9: c.imm_n = wide;
            8'hC2, 8'hC8, 8'hCA: c.imm_n = 3'd2;
            8'h6B, 8'h80, 8'h82, 8'h83, 8'hC0, 8'hC1, 8'hC6: begin
               c.need_modrm = 1'b1;
               c.imm_n      = 3'd1;
            end
            8'h81, 8'hC7: begin
               c.need_modrm = 1'b1;
               c.imm_n      = wide;
            end
            8'b1000_01??, 8'b1000_1???, 8'h69, 8'hD9, 8'hDB, 8'hFE, 8'hFF:
               c.need_modrm = 1'b1;
            // moffs forms and call/jmp rel32 keep 4 bytes regardless of 66
            8'b1010_00??, 8'hE8, 8'hE9: mark_rel4(c, pos);
            default: ;
         endcase
      end
   endfunction

   function automatic void class_escaped(inout dec_ctx_type c, input logic [7:0] op,
                                         input logic [3:0] pos);
      casez (op)
         8'h8?: begin
            if (c.opsz) c.disp_n = 3'd2;
            else mark_rel4(c, pos);
         end
         8'h1F, 8'h9?, 8'hB6, 8'hB7: c.need_modrm = 1'b1;
         8'hBA: begin
            c.need_modrm = 1'b1;
            c.imm_n      = 3'd1;
         end
         default: ;
      endcase
   endfunction

   // returns 1 when no displacement or immediate byte is left
   function automatic bit enter_tail(inout dec_ctx_type c);
      if (c.disp_n != 3'd0) begin
         c.st     = ST_DISP;
         c.left_n = c.disp_n;
         return 1'b0;
      end
      if (c.imm_n != 3'd0) begin
         c.st     = ST_IMM;
         c.left_n = c.imm_n;
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic bit after_opcode(inout dec_ctx_type c);
      if (c.need_modrm) begin
         c.st = ST_MODRM;
         return 1'b0;
      end
      return enter_tail(c);
   endfunction

   // advance the length decode by one byte; 1 when an instruction ends
   function automatic bit decode_byte(inout dec_ctx_type c, input logic [7:0] b,
                                      output rsp_type r);
      logic [3:0] pos;
      bit         fin;
      pos = c.len_acc + 4'd1;
      fin = 1'b0;
      r   = '0;
      case (c.st)
         ST_OP2: begin
            class_escaped(c, b, pos);
            fin = after_opcode(c);
         end
         ST_MODRM: begin
            c.need_modrm = 1'b0;
            if (b[7:6] != MOD_REG) begin
               if (b[7:6] == MOD_D8) c.disp_n = 3'd1;
               else if (b[7:6] == MOD_D32) c.disp_n = 3'd4;
               else if (b[2:0] == RM_RIP) mark_rel4(c, pos);
            end
            if (b[7:6] != MOD_REG && b[2:0] == RM_SIB) c.st = ST_SIB;
            else fin = enter_tail(c);
         end
         ST_SIB: fin = enter_tail(c);
         ST_DISP: begin
            if (c.left_n != 3'd0) c.left_n = c.left_n - 3'd1;
            if (c.left_n == 3'd0) begin
               c.disp_n = 3'd0;
               fin = enter_tail(c);
            end
         end
         ST_IMM: begin
            if (c.left_n != 3'd0) c.left_n = c.left_n - 3'd1;
            fin = (c.left_n == 3'd0);
         end
         default: begin
            c.st = ST_LEAD;
            case (b)
               PFX_LOCK, PFX_REPNE, PFX_REP, PFX_OPSZ, PFX_ADSZ, PFX_FS, PFX_GS: begin
                  if (b == PFX_OPSZ) c.opsz = 1'b1;
               end
               OP_ESC: c.st = ST_OP2;
               default: begin
                  class_primary(c, b, pos);
                  fin = after_opcode(c);
               end
            endcase
         end
      endcase
      if (fin || pos >= MAX_LENGTH) begin
         r.instr_length = pos;
         r.rel_present  = c.rel_f;
         r.rel_offset   = c.rel_f ? c.rel_pos : 4'd0;
         r.too_long     = !fin;
         c = ctx_clear();
         return 1'b1;
      end
      c.len_acc = pos;
      return 1'b0;
   endfunction

   // queue a byte for the driver; the generator side tracks instruction bounds
   function automatic bit push_byte(input logic [7:0] b);
      rsp_type r;
      pending_bytes.push_back(b);
      return decode_byte(gen_ctx, b, r);
   endfunction

   function automatic logic [7:0] pick_prefix();
      case ($urandom_range(6))
         0: return PFX_LOCK;
         1: return PFX_REPNE;
         2: return PFX_REP;
         3: return PFX_OPSZ;
         4: return PFX_ADSZ;
         5: return PFX_FS;
         default: return PFX_GS;
      endcase
   endfunction

   task automatic gen_instruction();
      int         n_pfx;
      int         kind;
      int         idx;
      logic [7:0] op;
      bit         fin;
      fin = 1'b0;
      // a few long prefix runs to hit the length limit
      n_pfx = ($urandom_range(19) == 0) ? $urandom_range(15, 10) : $urandom_range(2);
      repeat (n_pfx) void'(push_byte(pick_prefix()));
      kind = $urandom_range(9);
      if (kind < 3) begin
         op = 8'($urandom_range(8'h3F));
      end else if (kind < 7) begin
         idx = $urandom_range($bits(LISTED_OPS) / 8 - 1);
         op  = LISTED_OPS[8*idx +: 8];
      end else if (kind < 9) begin
         void'(push_byte(OP_ESC));
         idx = $urandom_range($bits(ESCAPED_OPS) / 8);
         if (idx == $bits(ESCAPED_OPS) / 8) op = 8'($urandom_range(255));
         else op = ESCAPED_OPS[8*idx +: 8];
      end else begin
         op = 8'($urandom_range(255));
      end
      fin = push_byte(op);
      while (!fin) fin = push_byte(8'($urandom_range(255)));
   endtask

   task automatic fill_random(input int n);
      int start;
      start = pending_bytes.size();
      while (pending_bytes.size() - start < n) begin
         if ($urandom_range(9) < 8) gen_instruction();
         else repeat ($urandom_range(6, 1)) void'(push_byte(8'($urandom_range(255))));
      end
   endtask

   task automatic drain_phase();
      do @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_lengths.size() != 0);
   endtask

   // sender: predict on acceptance, then offer the next queued byte
   always @(posedge clock) begin : byte_driver
      rsp_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            n_sent++;
            if (decode_byte(dut_ctx, req_code_byte, r)) expected_lengths.push_back(r);
         end
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid     <= 1'b1;
               req_code_byte <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_tag != hold_taken) begin
         hold_taken <= hold_tag;
         hold_left  <= HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_instr_length, rsp_rel_present, rsp_rel_offset, rsp_too_long};
         if (expected_lengths.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result: len %0d rel %0b off %0d too_long %0b",
                        got.instr_length, got.rel_present, got.rel_offset, got.too_long);
         end else begin
            want = expected_lengths.pop_front();
            n_checked++;
            if (want.too_long) n_too_long++;
            if (want.rel_present) n_rel++;
            if (got.instr_length !== want.instr_length ||
                got.rel_present !== want.rel_present ||
                got.rel_offset !== want.rel_offset || got.too_long !== want.too_long) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("result %0d: expected len %0d rel %0b off %0d too_long %0b",
                           n_checked, want.instr_length, want.rel_present,
                           want.rel_offset, want.too_long);
                  $display("result %0d: got      len %0d rel %0b off %0d too_long %0b",
                           n_checked, got.instr_length, got.rel_present,
                           got.rel_offset, got.too_long);
               end
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      dut_ctx = ctx_clear();
      gen_ctx = ctx_clear();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = $bits(DIRECTED_BYTES) / 8 - 1; i >= 0; i--)
         void'(push_byte(DIRECTED_BYTES[8*i +: 8]));
      repeat (15) void'(push_byte(PFX_OPSZ));
      repeat (14) void'(push_byte(PFX_REP));
      // call opcode lands on the last allowed byte, relative field at offset 15
      void'(push_byte(8'hE8));
      repeat (4) void'(push_byte(8'h90));
      fill_random(80);
      drain_phase();

      send_idle_pct  = 70;
      recv_stall_pct = 0;
      fill_random(180);
      drain_phase();

      send_idle_pct  = 0;
      recv_stall_pct = 70;
      fill_random(180);
      drain_phase();

      send_idle_pct  = 38;
      recv_stall_pct = 38;
      fill_random(180);
      drain_phase();

      // long receiver hold while the sender keeps pushing
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_tag       = hold_tag + 1;
      fill_random(120);
      drain_phase();

      repeat (10) @(negedge clock);
      $display("Sent %0d bytes, checked %0d lengths (%0d cut, %0d with a relative field).",
               n_sent, n_checked, n_too_long, n_rel);
      $display("Traffic ran without gaps, with sender gaps, receiver stalls, both, and one long receiver hold.");
      if (mismatches == 0 && expected_lengths.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
